/* hw/rtl/gbfp_pkg.sv */
// shared types and constants of the binary frame parser
package gbfp_pkg;

  localparam logic [7:0] SyncFirst  = 8'hB5;
  localparam logic [7:0] SyncSecond = 8'h62;
  localparam logic [15:0] MaxLenReset = 16'd256;

  // parse phase codes
  typedef enum logic [3:0] {
    PH_SYNC1   = 4'd0,
    PH_SYNC2   = 4'd1,
    PH_CLASS   = 4'd2,
    PH_ID      = 4'd3,
    PH_LENLO   = 4'd4,
    PH_LENHI   = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_CKA     = 4'd7,
    PH_CKB     = 4'd8
  } phase_e;

  typedef struct packed {
    phase_e      phase;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] length;
    logic [15:0] filled;
    logic [7:0]  sum_a;
    logic [7:0]  sum_b;
    logic [7:0]  rx_sum_a;
    logic [31:0] good_total;
    logic [31:0] bad_total;
  } parse_state_t;

  // per-byte pulses and payload forwarding
  typedef struct packed {
    logic        frame_good;
    logic        frame_rejected;
    logic        payload_valid;
    logic [7:0]  payload_data;
    logic [15:0] payload_index;
  } byte_result_t;

  localparam int TdataW = 120;
  localparam int TuserW = 3;

endpackage

/* hw/rtl/gbfp_step.sv */
// next-state and per-byte result logic of the frame parser
module gbfp_step (
  input  gbfp_pkg::parse_state_t st_i,
  input  logic [7:0]             rx_byte_i,
  input  logic [15:0]            max_len_i,
  output gbfp_pkg::parse_state_t st_o,
  output gbfp_pkg::byte_result_t res_o
);
  import gbfp_pkg::*;

  logic [7:0]  sum_a_add;
  logic [7:0]  sum_b_add;
  logic [15:0] len_full;
  logic [15:0] filled_inc;

  assign sum_a_add  = st_i.sum_a + rx_byte_i;
  assign sum_b_add  = st_i.sum_b + sum_a_add;
  assign len_full   = {rx_byte_i, st_i.length[7:0]};
  assign filled_inc = st_i.filled + 16'd1;

  always_comb begin
    st_o  = st_i;
    res_o = '0;
    unique case (st_i.phase)
      PH_SYNC1: begin
        if (rx_byte_i == SyncFirst) st_o.phase = PH_SYNC2;
      end
      PH_SYNC2: begin
        if (rx_byte_i == SyncSecond) begin
          st_o.length = '0;
          st_o.filled = '0;
          st_o.sum_a  = '0;
          st_o.sum_b  = '0;
          st_o.phase  = PH_CLASS;
        end else if (rx_byte_i == SyncFirst) begin
          st_o.phase = PH_SYNC2;
        end else begin
          st_o.phase = PH_SYNC1;
        end
      end
      PH_CLASS: begin
        st_o.msg_class = rx_byte_i;
        st_o.sum_a     = sum_a_add;
        st_o.sum_b     = sum_b_add;
        st_o.phase     = PH_ID;
      end
      PH_ID: begin
        st_o.msg_id = rx_byte_i;
        st_o.sum_a  = sum_a_add;
        st_o.sum_b  = sum_b_add;
        st_o.phase  = PH_LENLO;
      end
      PH_LENLO: begin
        st_o.length = {8'h00, rx_byte_i};
        st_o.sum_a  = sum_a_add;
        st_o.sum_b  = sum_b_add;
        st_o.phase  = PH_LENHI;
      end
      PH_LENHI: begin
        st_o.length = len_full;
        st_o.sum_a  = sum_a_add;
        st_o.sum_b  = sum_b_add;
        if (len_full > max_len_i) begin
          st_o.bad_total       = st_i.bad_total + 32'd1;
          res_o.frame_rejected = 1'b1;
          st_o.phase           = PH_SYNC1;
        end else if (len_full == 16'd0) begin
          st_o.phase = PH_CKA;
        end else begin
          st_o.phase = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        res_o.payload_valid = 1'b1;
        res_o.payload_data  = rx_byte_i;
        res_o.payload_index = st_i.filled;
        st_o.filled         = filled_inc;
        st_o.sum_a          = sum_a_add;
        st_o.sum_b          = sum_b_add;
        if (filled_inc >= st_i.length) st_o.phase = PH_CKA;
      end
      PH_CKA: begin
        st_o.rx_sum_a = rx_byte_i;
        st_o.phase    = PH_CKB;
      end
      PH_CKB: begin
        st_o.phase = PH_SYNC1;
        if (st_i.rx_sum_a == st_i.sum_a && rx_byte_i == st_i.sum_b) begin
          st_o.good_total  = st_i.good_total + 32'd1;
          res_o.frame_good = 1'b1;
        end else begin
          st_o.bad_total       = st_i.bad_total + 32'd1;
          res_o.frame_rejected = 1'b1;
        end
      end
      default: begin
        st_o.phase = PH_SYNC1;
      end
    endcase
  end

endmodule

/* hw/rtl/gnss_binary_frame_parser.sv */
// top level of the byte-serial binary navigation frame parser
//
// Takes one received byte per request on the slave stream and returns exactly
// one result per byte on the master stream. The parser hunts for the sync pair
// 0xB5 0x62, then reads class, id and a little-endian 16-bit length, forwards
// every payload byte with its index, and checks the two 8-bit Fletcher sums
// that run over class, id, length and payload. On the final checksum byte it
// pulses frame_good or frame_rejected and bumps the matching wrapping 32-bit
// counter; a length above max_payload_length is rejected on the second length
// byte and hunting resumes. The parse state and the two sum adders update on the
// edge that accepts a byte, and the result is loaded into the output register
// on that same edge. A new byte is accepted every cycle as long as the output
// register is empty or being taken downstream, so the block sustains one byte
// per clock. max_payload_length resets to 256 and should only be written while
// no byte is in flight.
module gnss_binary_frame_parser (
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration: max_payload_length
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i,
  // byte input
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
  // result output
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [7:0] payload_data, [23:8] payload_index, [31:24] msg_class,
  // [39:32] msg_id, [55:40] payload_length, [87:56] good_count,
  // [119:88] bad_count
  output logic [gbfp_pkg::TdataW-1:0] m_axis_tdata,
  // [0] frame_good, [1] frame_rejected, [2] payload_valid
  output logic [gbfp_pkg::TuserW-1:0] m_axis_tuser
);
  import gbfp_pkg::*;

  logic [15:0]  max_len_q;
  parse_state_t st_q, st_d;
  byte_result_t res;
  logic         in_accept;

  logic                 out_valid_q, out_valid_d;
  logic [TdataW-1:0]    out_data_q, out_data_d;
  logic [TuserW-1:0]    out_user_q, out_user_d;

  // length limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenReset;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  // take a byte whenever the output slot is free or drains this cycle
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  gbfp_step u_step (
    .st_i      (st_q),
    .rx_byte_i (s_axis_tdata),
    .max_len_i (max_len_q),
    .st_o      (st_d),
    .res_o     (res)
  );

  // parse state advances only on an accepted byte
  // all-zero state is hunting for the first sync byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (in_accept) begin
      st_q <= st_d;
    end
  end

  // result register: header fields and counters show the state after the byte
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;
    if (in_accept) begin
      out_valid_d = 1'b1;
      out_data_d  = {st_d.bad_total, st_d.good_total, st_d.length,
                     st_d.msg_id, st_d.msg_class,
                     res.payload_index, res.payload_data};
      out_user_d  = {res.payload_valid, res.frame_rejected, res.frame_good};
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // payload of the result needs no reset
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

/* hw/rtl/gbfp_checker.sv */
// port-level checks of the frame parser and their bind
module gbfp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_we_i,
  input logic [15:0]                   cfg_wdata_i,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [7:0]                    s_axis_tdata,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [gbfp_pkg::TdataW-1:0]   m_axis_tdata,
  input logic [gbfp_pkg::TuserW-1:0]   m_axis_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // every accepted byte shows a result in the next cycle
  a_byte_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted byte produced no result");

  // good, rejected and payload are mutually exclusive
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $onehot0(m_axis_tuser))
    else $error("more than one result flag set");

  // payload fields are zero outside the payload
  a_payload_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[2] |-> m_axis_tdata[23:0] == 24'd0)
    else $error("payload fields set on a non-payload byte");

  // free output slot always takes a byte
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

endmodule

bind gnss_binary_frame_parser gbfp_checker u_gbfp_checker (.*);

/* tb/sv/tb_gnss_binary_frame_parser.sv */
// self-checking testbench of the binary frame parser: directed rows, then random frames
module tb_gnss_binary_frame_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import gbfp_pkg::*;

  localparam int QuietLimit  = 2000;  // cycles with no request on either side
  localparam int ReportLimit = 10;

  // one result as the parser reports it, unpacked from tdata and tuser
  typedef struct packed {
    logic        good;
    logic        rejected;
    logic        pvalid;
    logic [7:0]  pdata;
    logic [15:0] pindex;
    logic [7:0]  cls;
    logic [7:0]  id;
    logic [15:0] len;
    logic [31:0] good_cnt;
    logic [31:0] bad_cnt;
  } frame_out_t;

  // one row of the directed table; want is used only where typed is set
  typedef struct packed {
    logic [7:0] rx;
    logic       typed;
    frame_out_t want;
  } stim_row_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [15:0]       cfg_wdata_i   = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [TdataW-1:0] m_axis_tdata;
  logic [TuserW-1:0] m_axis_tuser;

  gnss_binary_frame_parser DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // predictor state, mirrors the parser registers
  logic [15:0] len_limit;
  phase_e      pr_phase;
  logic [7:0]  pr_class;
  logic [7:0]  pr_id;
  logic [15:0] pr_len;
  logic [15:0] pr_filled;
  logic [7:0]  pr_sum_a;
  logic [7:0]  pr_sum_b;
  logic [7:0]  pr_rx_ck_a;
  logic [31:0] pr_good;
  logic [31:0] pr_bad;

  frame_out_t results_due[$];     // expected results, oldest first
  stim_row_t  directed_rows[$];
  int         mismatch_count = 0;
  int         quiet_cycles   = 0;
  int         live_bytes     = 0;  // bytes the parser does not simply drop
  bit         gaps_allowed   = 1'b1;
  bit         send_gaps      = 1'b1;
  bit         recv_stalls    = 1'b1;

  // 4 ns clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // 8-bit fletcher step over class, id, length and payload
  function automatic void fletcher_add(input logic [7:0] b);
    pr_sum_a = pr_sum_a + b;
    pr_sum_b = pr_sum_b + pr_sum_a;
  endfunction

  // advance the predictor by one accepted byte and return the result it causes
  function automatic frame_out_t parse_byte(input logic [7:0] b);
    frame_out_t r;
    r = '0;
    case (pr_phase)
      PH_SYNC1: begin
        if (b == SyncFirst) pr_phase = PH_SYNC2;
      end
      PH_SYNC2: begin
        if (b == SyncSecond) begin
          // frame start clears length, fill count and sums, class and id stay
          pr_len    = '0;
          pr_filled = '0;
          pr_sum_a  = '0;
          pr_sum_b  = '0;
          pr_phase  = PH_CLASS;
        end else begin
          // a repeated first sync byte keeps waiting for the second one
          pr_phase = (b == SyncFirst) ? PH_SYNC2 : PH_SYNC1;
        end
      end
      PH_CLASS: begin
        pr_class = b;
        fletcher_add(b);
        pr_phase = PH_ID;
      end
      PH_ID: begin
        pr_id = b;
        fletcher_add(b);
        pr_phase = PH_LENLO;
      end
      PH_LENLO: begin
        pr_len = {8'h00, b};
        fletcher_add(b);
        pr_phase = PH_LENHI;
      end
      PH_LENHI: begin
        pr_len = {b, pr_len[7:0]};
        fletcher_add(b);
        if (pr_len > len_limit) begin
          // oversize: rejected at once, length register keeps the value
          pr_bad     = pr_bad + 32'd1;
          r.rejected = 1'b1;
          pr_phase   = PH_SYNC1;
        end else begin
          pr_phase = (pr_len == 16'd0) ? PH_CKA : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        r.pvalid  = 1'b1;
        r.pdata   = b;
        r.pindex  = pr_filled;
        pr_filled = pr_filled + 16'd1;
        fletcher_add(b);
        if (pr_filled >= pr_len) pr_phase = PH_CKA;
      end
      PH_CKA: begin
        pr_rx_ck_a = b;
        pr_phase   = PH_CKB;
      end
      PH_CKB: begin
        pr_phase = PH_SYNC1;
        if (pr_rx_ck_a == pr_sum_a && b == pr_sum_b) begin
          pr_good = pr_good + 32'd1;
          r.good  = 1'b1;
        end else begin
          pr_bad     = pr_bad + 32'd1;
          r.rejected = 1'b1;
        end
      end
      default: begin
        pr_phase = PH_SYNC1;
      end
    endcase
    r.cls      = pr_class;
    r.id       = pr_id;
    r.len      = pr_len;
    r.good_cnt = pr_good;
    r.bad_cnt  = pr_bad;
    return r;
  endfunction

  function automatic void add_row(input logic [7:0] b);
    directed_rows.push_back({b, 1'b0, frame_out_t'('0)});
  endfunction

  function automatic void add_typed(input logic [7:0] b, input frame_out_t want);
    directed_rows.push_back({b, 1'b1, want});
  endfunction

  // offer one byte, wait for the request to be taken, then book its result;
  // valid stays high on return so back-to-back bytes need no extra edge
  task automatic send_byte(input logic [7:0] b, input logic typed, input frame_out_t want);
    frame_out_t pred;
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    if (pr_phase != PH_SYNC1 || b == SyncFirst) live_bytes++;
    pred = parse_byte(b);
    results_due.push_back(typed ? want : pred);
  endtask

  // stop sending and let every booked result come out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // max_payload_length is only written with nothing in flight
  task automatic write_len_limit(input logic [15:0] v);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    len_limit = v;
    cfg_we_i <= 1'b0;
  endtask

  // one frame with random class, id and payload; stops after the length
  // when it is oversize, otherwise ends in a sound or a corrupted checksum
  task automatic send_frame(input logic [15:0] len, input bit sound_ck);
    logic [7:0] ca;
    logic [7:0] cb;
    logic [7:0] v;
    int         i;
    ca = '0;
    cb = '0;
    send_byte(SyncFirst, 1'b0, '0);
    send_byte(SyncSecond, 1'b0, '0);
    for (i = 0; i < 4; i++) begin
      case (i)
        0, 1:    v = 8'($urandom);
        2:       v = len[7:0];
        default: v = len[15:8];
      endcase
      ca = ca + v;
      cb = cb + ca;
      send_byte(v, 1'b0, '0);
    end
    if (len <= len_limit) begin
      for (i = 0; i < int'(len); i++) begin
        v  = 8'($urandom);
        ca = ca + v;
        cb = cb + ca;
        send_byte(v, 1'b0, '0);
      end
      if (!sound_ck) begin
        if ($urandom_range(0, 1) == 0) ca = ca ^ (8'h01 << $urandom_range(0, 7));
        else cb = cb ^ (8'h01 << $urandom_range(0, 7));
      end
      send_byte(ca, 1'b0, '0);
      send_byte(cb, 1'b0, '0);
    end
  endtask

  // mostly well-formed frames, the rest line noise and broken headers
  task automatic random_traffic(input int quota, input bit allow_broken);
    int          pick;
    int          stop_at;
    logic [15:0] len;
    logic [7:0]  v;
    stop_at = live_bytes + quota;
    while (live_bytes < stop_at) begin
      send_gaps = gaps_allowed && ($urandom_range(0, 9) < 7);
      pick = allow_broken ? $urandom_range(0, 99) : 0;
      if (pick < 75) begin
        pick = $urandom_range(0, 9);
        if (pick == 0 && len_limit != 16'hFFFF) begin
          len = 16'($urandom_range(int'(len_limit) + 1, 65535));
        end else if (pick == 1 && len_limit <= 16'd300) begin
          len = len_limit;                  // largest length still accepted
        end else if (pick == 2 && len_limit < 16'd300) begin
          len = len_limit + 16'd1;          // smallest oversize length
        end else begin
          len = 16'($urandom_range(0, 12));
        end
        send_frame(len, $urandom_range(0, 4) != 0);
      end else if (pick < 88) begin
        // noise, rich in sync bytes
        repeat ($urandom_range(1, 6)) begin
          pick = $urandom_range(0, 2);
          v = 8'($urandom);
          if (pick == 0) v = SyncFirst;
          else if (pick == 1) v = SyncSecond;
          send_byte(v, 1'b0, '0);
        end
      end else begin
        // repeated first sync, then a header cut short or a false second sync
        repeat ($urandom_range(1, 3)) send_byte(SyncFirst, 1'b0, '0);
        if ($urandom_range(0, 1) == 0) begin
          send_byte(SyncSecond, 1'b0, '0);
          repeat ($urandom_range(0, 2)) begin
            v = 8'($urandom);
            send_byte(v, 1'b0, '0);
          end
        end else begin
          v = 8'($urandom_range(0, 8'h61));
          send_byte(v, 1'b0, '0);
        end
      end
    end
  endtask

  // result side: ready toggles in short random stalls
  initial begin
    forever begin
      if (recv_stalls && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  end

  task automatic note_diff(input string what, input logic [31:0] want, input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= ReportLimit) begin
      $display("%0t ns: %s expected %0h got %0h", $time, what, want, got);
    end
  endtask

  // compare every taken result with the oldest booked one
  always @(posedge clk_i) begin : check_result
    frame_out_t seen;
    frame_out_t due;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen = {m_axis_tuser[0], m_axis_tuser[1], m_axis_tuser[2],
              m_axis_tdata[7:0], m_axis_tdata[23:8], m_axis_tdata[31:24],
              m_axis_tdata[39:32], m_axis_tdata[55:40], m_axis_tdata[87:56],
              m_axis_tdata[119:88]};
      if (results_due.size() == 0) begin
        note_diff("result with nothing due, payload_length", '0, seen.len);
      end else begin
        due = results_due.pop_front();
        if (seen.good !== due.good) note_diff("frame_good", due.good, seen.good);
        if (seen.rejected !== due.rejected) begin
          note_diff("frame_rejected", due.rejected, seen.rejected);
        end
        if (seen.pvalid !== due.pvalid) note_diff("payload_valid", due.pvalid, seen.pvalid);
        if (seen.pdata !== due.pdata) note_diff("payload_data", due.pdata, seen.pdata);
        if (seen.pindex !== due.pindex) note_diff("payload_index", due.pindex, seen.pindex);
        if (seen.cls !== due.cls) note_diff("msg_class", due.cls, seen.cls);
        if (seen.id !== due.id) note_diff("msg_id", due.id, seen.id);
        if (seen.len !== due.len) note_diff("payload_length", due.len, seen.len);
        if (seen.good_cnt !== due.good_cnt) note_diff("good_count", due.good_cnt, seen.good_cnt);
        if (seen.bad_cnt !== due.bad_cnt) note_diff("bad_count", due.bad_cnt, seen.bad_cnt);
      end
    end
  end

  // watchdog: too long without any request taken on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("tb_gnss_binary_frame_parser: errors");
      $finish;
    end
  end

  initial begin : run_stimulus
    int i;

    // predictor matches the parser after reset
    len_limit  = MaxLenReset;
    pr_phase   = PH_SYNC1;
    pr_class   = '0;
    pr_id      = '0;
    pr_len     = '0;
    pr_filled  = '0;
    pr_sum_a   = '0;
    pr_sum_b   = '0;
    pr_rx_ck_a = '0;
    pr_good    = '0;
    pr_bad     = '0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table, limit still at its reset value of 256
    add_typed(8'h00, '0);                        // hunting, everything still zero
    add_row(SyncFirst);
    add_row(SyncFirst);                          // repeated first sync keeps waiting
    add_row(SyncSecond);
    add_row(8'hFF);                              // class, all ones
    add_row(8'h00);                              // id, all zeros
    add_row(8'hFF);
    // length 0xffff is far above 256: rejected on the second length byte
    add_typed(8'hFF, {1'b0, 1'b1, 1'b0, 8'h00, 16'h0000, 8'hFF, 8'h00, 16'hFFFF,
                      32'd0, 32'd1});
    add_row(SyncFirst);
    add_row(8'h07);                              // false second sync, back to hunting
    // zero-length frame, straight from length to a sound checksum
    add_row(SyncFirst);
    add_row(SyncSecond);
    add_row(8'h01);
    add_row(8'h07);
    add_row(8'h00);
    add_row(8'h00);
    add_row(8'h08);
    add_typed(8'h19, {1'b1, 1'b0, 1'b0, 8'h00, 16'h0000, 8'h01, 8'h07, 16'h0000,
                      32'd1, 32'd1});
    // one payload byte, checksum bytes wrong
    add_row(SyncFirst);
    add_row(SyncSecond);
    add_row(8'h0A);
    add_row(8'h0B);
    add_row(8'h01);
    add_row(8'h00);
    add_row(8'hFF);
    add_row(8'h00);
    add_typed(8'h00, {1'b0, 1'b1, 1'b0, 8'h00, 16'h0000, 8'h0A, 8'h0B, 16'h0001,
                      32'd1, 32'd2});
    for (i = 0; i < directed_rows.size(); i++) begin
      send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].want);
    end

    // limit zero: only zero-length frames pass
    write_len_limit(16'd0);
    random_traffic(60, 1'b1);

    // limit at its top: no length field is oversize
    write_len_limit(16'hFFFF);
    random_traffic(40, 1'b0);

    write_len_limit(16'd20);
    random_traffic(100, 1'b1);

    write_len_limit(16'($urandom_range(1, 300)));
    random_traffic(100, 1'b1);

    // last part runs back to back on both sides
    write_len_limit(MaxLenReset);
    gaps_allowed = 1'b0;
    recv_stalls  = 1'b0;
    random_traffic(100, 1'b1);

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_gnss_binary_frame_parser: clean");
    end else begin
      $display("tb_gnss_binary_frame_parser: errors");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/gbfp_pkg.sv
hw/rtl/gbfp_step.sv
hw/rtl/gnss_binary_frame_parser.sv
hw/rtl/gbfp_checker.sv
tb/sv/tb_gnss_binary_frame_parser.sv
